// ===== rtl/first_fit_region_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// first_fit_region_allocator_defines
// Assertion macros used by the checker of the region allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define FFRA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffra assertion failed");

// Next-cycle implication, quiet while reset is high.
`define FFRA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffra assertion failed");

`endif

// ===== rtl/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg
// Types, codes and sizes of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

   localparam int MAX_REGIONS  = 16;
   localparam int IDX_W        = $clog2(MAX_REGIONS);
   localparam int CNT_W        = $clog2(MAX_REGIONS + 1);

   localparam int TAG_W        = 8;
   localparam int SIZE_W       = 16;
   localparam int NEED_W       = SIZE_W + 1;
   localparam int FROM_W       = SIZE_W + 2;
   localparam int SUM_W        = SIZE_W + 3;

   localparam logic [NEED_W-1:0] HEADER_WORDS = NEED_W'(5);
   localparam logic [FROM_W-1:0] GUARD_WORDS  = FROM_W'(1);
   localparam logic [SIZE_W-1:0] MEM_SIZE_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_PROBE = 2'd1,
      OP_FREE  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_TOO_LARGE = 3'd1,
      STATUS_NO_GAP    = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] start;
      logic [SIZE_W-1:0] total;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } ram_req_type;

endpackage

// ===== rtl/ffra_table_ram.sv =====
// ----------------------------------------------------------------------------
// ffra_table_ram
// Region table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffra_table_ram (
   input  logic                 clock,
   input  ffra_pkg::ram_req_type req,
   output ffra_pkg::entry_type  rd_data
);
   import ffra_pkg::*;

   entry_type mem [MAX_REGIONS];

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[req.raddr];
   end

endmodule

// ===== rtl/ffra_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffra_ctrl
// Request sequencer: size checks, first-fit scan, insert and delete ripples.
// ----------------------------------------------------------------------------
module ffra_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_operation,
   input  logic [ffra_pkg::TAG_W-1:0]   req_program_tag,
   input  logic [ffra_pkg::SIZE_W-1:0]  req_overlay_size,
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_status,
   output logic [ffra_pkg::SIZE_W-1:0]  rsp_region_start,
   input  logic                         csr_wr_en,
   input  logic [ffra_pkg::SIZE_W-1:0]  csr_wr_data,
   output ffra_pkg::ram_req_type        ram_req,
   input  ffra_pkg::entry_type          ram_rd_data
);
   import ffra_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_INS  = 4'b0100,
      ST_DEL  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [NEED_W-1:0]  need_ff, need_in;
   logic [FROM_W-1:0]  from_ff, from_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   entry_type          carry_ff, carry_in;
   logic [SIZE_W-1:0]  mem_size_ff, mem_size_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SIZE_W-1:0]  rsp_start_ff, rsp_start_in;

   logic [NEED_W-1:0]  req_need;
   logic [SUM_W-1:0]   fit_end;
   logic [CNT_W-1:0]   idx_dec;
   logic               in_range;
   logic               fits;

   assign req_need = {1'b0, req_overlay_size} + HEADER_WORDS;
   assign fit_end  = {1'b0, from_ff} + {2'b0, need_ff};
   assign idx_dec  = idx_ff - CNT_W'(1);
   assign in_range = idx_ff < count_ff;
   // Gap ends at the next start, or at the top of memory past the last entry.
   assign fits     = in_range ? ({3'b0, ram_rd_data.start} >= fit_end)
                              : ({3'b0, mem_size_ff} >= fit_end);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      need_in       = need_ff;
      from_in       = from_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      carry_in      = carry_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      mem_size_in   = csr_wr_en ? csr_wr_data : mem_size_ff;

      ram_req.we    = 1'b0;
      ram_req.waddr = idx_ff[IDX_W-1:0];
      ram_req.wdata = carry_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in   = op_type'(req_operation);
               tag_in  = req_program_tag;
               need_in = req_need;
               from_in = '0;
               idx_in  = '0;
               priority if ((op_type'(req_operation) == OP_ALLOC ||
                             op_type'(req_operation) == OP_PROBE) &&
                            ({1'b0, mem_size_ff} < req_need)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_TOO_LARGE;
                  rsp_start_in  = '0;
               end else if (op_type'(req_operation) == OP_ALLOC &&
                            count_ff == CNT_W'(MAX_REGIONS)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FULL;
                  rsp_start_in  = '0;
               end else if (op_type'(req_operation) == OP_NOP) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_start_in  = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (op_ff == OP_FREE) begin
               if (in_range) begin
                  idx_in = idx_ff + CNT_W'(1);
                  if (ram_rd_data.tag == tag_ff) begin
                     rsp_start_in = ram_rd_data.start;
                     state_in     = ST_DEL;
                  end
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NOT_FOUND;
                  rsp_start_in  = '0;
                  state_in      = ST_IDLE;
               end
            end else if (fits) begin
               rsp_status_in = STATUS_OK;
               rsp_start_in  = from_ff[SIZE_W-1:0];
               if (op_ff == OP_PROBE) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  // Drop the new entry here and carry the displaced one upward.
                  ram_req.we    = 1'b1;
                  ram_req.wdata = '{tag: tag_ff, start: from_ff[SIZE_W-1:0],
                                    total: need_ff[SIZE_W-1:0]};
                  carry_in      = ram_rd_data;
                  if (in_range) begin
                     idx_in   = idx_ff + CNT_W'(1);
                     state_in = ST_INS;
                  end else begin
                     count_in     = count_ff + CNT_W'(1);
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
            end else if (in_range) begin
               from_in = {2'b0, ram_rd_data.start} + {2'b0, ram_rd_data.total}
                       + GUARD_WORDS;
               idx_in  = idx_ff + CNT_W'(1);
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NO_GAP;
               rsp_start_in  = '0;
               state_in      = ST_IDLE;
            end
         end

         ST_INS: begin
            ram_req.we = 1'b1;
            if (in_range) begin
               carry_in = ram_rd_data;
               idx_in   = idx_ff + CNT_W'(1);
            end else begin
               count_in     = count_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_DEL: begin
            // Pull each later entry down by one slot.
            if (in_range) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = idx_dec[IDX_W-1:0];
               ram_req.wdata = ram_rd_data;
               idx_in        = idx_ff + CNT_W'(1);
            end else begin
               count_in      = idx_dec;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ram_req.raddr = idx_in[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         mem_size_ff  <= MEM_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         mem_size_ff  <= mem_size_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      need_ff       <= need_in;
      from_ff       <= from_in;
      idx_ff        <= idx_in;
      carry_ff      <= carry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_region_start = rsp_start_ff;

endmodule

// ===== rtl/first_fit_region_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// Allocates, probes and frees tagged memory regions, first fit from address 0.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on the rsp_ ports for one cycle with rsp_valid high and cannot be
// stalled, so the receiver must capture it then. Size-check, table-full and
// unused-operation requests answer in the cycle after they are taken. Others
// walk the region table one entry per cycle through its single read port and
// shift entries one per cycle through its single write port. busy stays high
// until the result cycle; the user must write memory_size through csr_wr_en /
// csr_wr_data only while the block is idle. The block itself does not enforce
// this.
module first_fit_region_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_operation,
   input  logic [ffra_pkg::TAG_W-1:0]   req_program_tag,
   input  logic [ffra_pkg::SIZE_W-1:0]  req_overlay_size,
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_status,
   output logic [ffra_pkg::SIZE_W-1:0]  rsp_region_start,
   input  logic                         csr_wr_en,
   input  logic [ffra_pkg::SIZE_W-1:0]  csr_wr_data
);
   import ffra_pkg::*;

   ram_req_type ram_req;
   entry_type   ram_rd_data;

   ffra_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_program_tag  (req_program_tag),
      .req_overlay_size (req_overlay_size),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_region_start (rsp_region_start),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .ram_req          (ram_req),
      .ram_rd_data      (ram_rd_data)
   );

   ffra_table_ram u_table (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== rtl/ffra_checker.sv =====
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks of the region allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_region_allocator_defines.svh"

module ffra_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic [2:0]                   rsp_status,
   input logic [ffra_pkg::SIZE_W-1:0]  rsp_region_start
);
   import ffra_pkg::*;

   // An accepted beat either answers at once or keeps the block busy.
   `FFRA_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy)
   // Leaving busy always comes with the result beat.
   `FFRA_ASSERT_NOW(a_done_has_result, clock, reset, $fell(busy), rsp_valid)
   `FFRA_ASSERT_NOW(a_result_when_idle, clock, reset, rsp_valid, !busy)
   `FFRA_ASSERT_NOW(a_fail_zero_start, clock, reset,
      rsp_valid && rsp_status != STATUS_OK, rsp_region_start == '0)
   `FFRA_ASSERT_NOW(a_status_legal, clock, reset, rsp_valid, rsp_status <= STATUS_FULL)

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_region_start (rsp_region_start)
);
